[hw/rtl/apn_pkg.sv]
// shared types and constants for the audio peak normalizer
package apn_pkg;

  localparam int BLOCK_DEPTH_DEF = 64;
  localparam int SAMPLE_W        = 16;
  localparam int TARGET_W        = 15;
  localparam int PEAK_W          = 17;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 15'd27571;
  localparam logic [SAMPLE_W-1:0] OUT_MAX      = 16'd32767;

  // input request payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       last_in;
  } in_item_t;

  // output request payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_out;
  } out_item_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE,
    B_READ,
    B_MUL,
    B_DIV,
    B_PUT
  } back_state_t;

endpackage

[hw/rtl/apn_store.sv]
// two-bank sample memory, one write port and one registered read port
module apn_store import apn_pkg::*; #(
  parameter  int BLOCK_DEPTH = BLOCK_DEPTH_DEF,
  localparam int AW          = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW:0]                wr_addr,
  input  logic [SAMPLE_W-1:0]        wr_data,
  input  logic                       rd_en,
  input  logic [AW:0]                rd_addr,
  output logic [SAMPLE_W-1:0]        rd_data
);

  logic [SAMPLE_W-1:0] mem [0:(2*(2**AW))-1];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/apn_front.sv]
// front end: takes samples, stores them, tracks the block peak, hands off blocks
module apn_front import apn_pkg::*; #(
  parameter  int BLOCK_DEPTH = BLOCK_DEPTH_DEF,
  localparam int AW          = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1,
  localparam int CW          = $clog2(BLOCK_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                wr_en,
  output logic [AW:0]         wr_addr,
  output logic [SAMPLE_W-1:0] wr_data,
  output logic                push,
  output logic                push_bank,
  output logic [CW-1:0]       push_count,
  output logic [PEAK_W-1:0]   push_peak,
  input  logic                fifo_full,
  input  logic                bank_rel,
  input  logic                bank_rel_id
);

  logic [CW-1:0]     cnt;
  logic [PEAK_W-1:0] peak;
  logic              bank;
  logic [1:0]        busy;
  logic [1:0]        busy_next;

  logic              accept;
  logic [CW-1:0]     cnt_inc;
  logic [PEAK_W-1:0] ext;
  logic [PEAK_W-1:0] mag;
  logic [PEAK_W-1:0] peak_new;
  logic              blk_end;

  // request acceptance: the target bank must be free of the back end and the queue must not be full
  assign in_stall = busy[bank] || fifo_full;
  assign accept   = in_valid && !in_stall;

  // magnitude and running peak
  always_comb begin
    ext      = PEAK_W'(in_item.sample_in);
    mag      = ext[PEAK_W-1] ? (~ext + PEAK_W'(1)) : ext;
    peak_new = (mag > peak) ? mag : peak;
    cnt_inc  = cnt + CW'(1);
    blk_end  = in_item.last_in || (cnt_inc == CW'(BLOCK_DEPTH));
  end

  // store write
  assign wr_en   = accept;
  assign wr_addr = {bank, cnt[AW-1:0]};
  assign wr_data = in_item.sample_in;

  // block hand-off
  assign push       = accept && blk_end;
  assign push_bank  = bank;
  assign push_count = cnt_inc;
  assign push_peak  = peak_new;

  // bank ownership: claimed on hand-off, freed when the back end finishes
  always_comb begin
    busy_next = busy;
    if (push) begin
      busy_next[bank] = 1'b1;
    end
    if (bank_rel) begin
      busy_next[bank_rel_id] = 1'b0;
    end
  end

  // block state and bank ownership
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      peak <= '0;
      bank <= 1'b0;
      busy <= 2'b00;
    end else begin
      if (accept) begin
        if (blk_end) begin
          cnt  <= '0;
          peak <= '0;
          bank <= ~bank;
        end else begin
          cnt  <= cnt_inc;
          peak <= peak_new;
        end
      end
      busy <= busy_next;
    end
  end

endmodule

[hw/rtl/apn_fifo.sv]
// two-entry queue of block descriptors between front and back end
module apn_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic          head_valid,
  output logic [DW-1:0] head_data,
  output logic          full
);

  logic [DW-1:0] entry [0:1];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign head_valid = (fill != 2'd0);
  assign full       = (fill == 2'd2);
  assign head_data  = entry[rd_ptr];

  // entry writes
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/apn_back.sv]
// back end: reads a block back, scales each sample by target/peak, emits results
module apn_back import apn_pkg::*; #(
  parameter  int BLOCK_DEPTH = BLOCK_DEPTH_DEF,
  localparam int AW          = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1,
  localparam int CW          = $clog2(BLOCK_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [TARGET_W-1:0] target_level,
  input  logic                desc_valid,
  input  logic                desc_bank,
  input  logic [CW-1:0]       desc_count,
  input  logic [PEAK_W-1:0]   desc_peak,
  output logic                desc_pop,
  output logic                rd_en,
  output logic [AW:0]         rd_addr,
  input  logic [SAMPLE_W-1:0] rd_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item
);

  back_state_t         state;
  back_state_t         state_next;
  logic [AW-1:0]       idx;
  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] low;
  logic [2:0]          iter;
  logic                neg;

  logic                out_free;
  logic                out_load;
  logic                blk_last;
  logic [PEAK_W-1:0]   ext;
  logic [PEAK_W-1:0]   mag;
  logic [31:0]         prod;
  logic [PEAK_W-1:0]   r1;
  logic [PEAK_W-1:0]   r2;
  logic [SAMPLE_W-1:0] r1_rem;
  logic [SAMPLE_W-1:0] r2_rem;
  logic                q1;
  logic                q2;
  logic [SAMPLE_W-1:0] res_mag;
  logic [SAMPLE_W-1:0] res_val;

  assign out_free = !out_valid || !out_stall;
  assign blk_last = ((CW'(idx) + CW'(1)) == desc_count);
  assign rd_addr  = {desc_bank, idx};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (desc_valid) state_next = B_READ;
      B_READ:  state_next = B_MUL;
      B_MUL:   state_next = B_DIV;
      B_DIV:   if (iter == 3'd7) state_next = B_PUT;
      B_PUT:   if (out_free) state_next = blk_last ? B_IDLE : B_READ;
      default: state_next = B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      B_READ:  rd_en = 1'b1;
      B_PUT:   out_load = out_free;
      default: begin
        rd_en    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end
  assign desc_pop = out_load && blk_last;

  // magnitude times target, quotient bounded to 16 bits
  always_comb begin
    ext  = PEAK_W'(signed'(rd_data));
    mag  = ext[PEAK_W-1] ? (~ext + PEAK_W'(1)) : ext;
    prod = 32'(mag) * 32'(target_level);
  end

  // two restoring division steps per cycle
  always_comb begin
    r1     = {rem, low[SAMPLE_W-1]};
    q1     = (r1 >= desc_peak);
    r1_rem = q1 ? SAMPLE_W'(r1 - desc_peak) : r1[SAMPLE_W-1:0];
    r2     = {r1_rem, low[SAMPLE_W-2]};
    q2     = (r2 >= desc_peak);
    r2_rem = q2 ? SAMPLE_W'(r2 - desc_peak) : r2[SAMPLE_W-1:0];
  end

  // silent block gives zero, clamp, restore sign
  always_comb begin
    if (desc_peak == '0) begin
      res_mag = '0;
    end else if (low > OUT_MAX) begin
      res_mag = OUT_MAX;
    end else begin
      res_mag = low;
    end
    res_val = neg ? (~res_mag + SAMPLE_W'(1)) : res_mag;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
        idx       <= blk_last ? '0 : idx + AW'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == B_MUL) begin
      rem  <= prod[31:16];
      low  <= prod[15:0];
      neg  <= rd_data[SAMPLE_W-1];
      iter <= 3'd0;
    end else if (state == B_DIV) begin
      rem  <= r2_rem;
      low  <= {low[SAMPLE_W-3:0], q1, q2};
      iter <= iter + 3'd1;
    end
    if (out_load) begin
      out_item.sample_out <= signed'(res_val);
      out_item.last_out   <= blk_last;
    end
  end

endmodule

[hw/rtl/audio_peak_normalizer_core.sv]
// Audio peak normalizer: block capture, peak tracking and per-sample scaling.
// Input channel (in_valid/in_stall/in_item) takes signed Q1.15 samples, one
// request per cycle while a bank is free. A request with last_in set, or the
// one that fills BLOCK_DEPTH entries, closes the block. Closed blocks wait in
// a two-entry queue; the store has two banks, so one block can load while the
// previous one drains. Output channel (out_valid/out_stall/out_item) returns
// every sample of the block in order, scaled by target_level/peak, truncated
// toward zero, with last_out on the final one. A silent block yields zeros.
// In the back end each output sample passes through a memory read, a multiply,
// a two-bit-per-cycle divider and the output load. The output register lets
// the divider work on the next sample while the receiver stalls; a stalled
// request holds. cfg_wr_en/cfg_wr_data write target_level, which resets to
// 27571 (-1.5 dBFS). Synchronous reset rst empties the queue, frees both
// banks and drops any pending output.
module audio_peak_normalizer_core import apn_pkg::*; #(
  parameter int BLOCK_DEPTH = BLOCK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [TARGET_W-1:0] cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item
);

  localparam int AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int CW = $clog2(BLOCK_DEPTH + 1);
  localparam int DW = 1 + CW + PEAK_W;

  logic [TARGET_W-1:0] target_level;

  logic                wr_en;
  logic [AW:0]         wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic                rd_en;
  logic [AW:0]         rd_addr;
  logic [SAMPLE_W-1:0] rd_data;

  logic                push;
  logic                push_bank;
  logic [CW-1:0]       push_count;
  logic [PEAK_W-1:0]   push_peak;
  logic                fifo_full;
  logic                head_valid;
  logic [DW-1:0]       head_data;
  logic                desc_pop;
  logic                desc_bank;
  logic [CW-1:0]       desc_count;
  logic [PEAK_W-1:0]   desc_peak;

  // target level register
  always_ff @(posedge clk) begin
    if (rst) begin
      target_level <= TARGET_RESET;
    end else if (cfg_wr_en) begin
      target_level <= cfg_wr_data;
    end
  end

  assign {desc_bank, desc_count, desc_peak} = head_data;

  apn_front #(
    .BLOCK_DEPTH(BLOCK_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .push        (push),
    .push_bank   (push_bank),
    .push_count  (push_count),
    .push_peak   (push_peak),
    .fifo_full   (fifo_full),
    .bank_rel    (desc_pop),
    .bank_rel_id (desc_bank)
  );

  apn_fifo #(
    .DW(DW)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_bank, push_count, push_peak}),
    .pop        (desc_pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .full       (fifo_full)
  );

  apn_store #(
    .BLOCK_DEPTH(BLOCK_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  apn_back #(
    .BLOCK_DEPTH(BLOCK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .target_level (target_level),
    .desc_valid   (head_valid),
    .desc_bank    (desc_bank),
    .desc_count   (desc_count),
    .desc_peak    (desc_peak),
    .desc_pop     (desc_pop),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_item     (out_item)
  );

endmodule
